// ===== hw/rtl/sgm_pkg.sv =====
// Shared constants, types and the square-root step for the Sobel gradient block.
// No dependencies.
package sgm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 11;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 10;
    localparam int CFG_W_W   = 11;
    localparam int CFG_H_W   = 12;
    localparam int SQ_W      = 21;
    localparam int MIN_DIM   = 3;

    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 12'd1024;

    // register select (address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // highest even bit position of the squared sum
    localparam logic [SQ_W-1:0] ROOT_BIT0 = SQ_W'(1) << (SQ_W - 1);

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
        logic [SQ_W-1:0] bitv;
    } t_sqrt_state;

    function automatic t_sqrt_state sqrt_step(t_sqrt_state s);
        t_sqrt_state o;
        logic [SQ_W:0] trial;
        trial  = {1'b0, s.res} + {1'b0, s.bitv};
        o.bitv = s.bitv >> 2;
        if ({1'b0, s.rem} >= trial) begin
            o.rem = s.rem - trial[SQ_W-1:0];
            o.res = (s.res >> 1) + s.bitv;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/sobel_gradient_magnitude.sv =====
// Sobel 3x3 gradient and magnitude over a raster pixel stream, one line memory.
// Depends on sgm_pkg.
// An interior pixel passes through the calculate and multiply states and the 11-step
// square-root unit, then waits in the final state until the output register is free; the
// next pixel is taken only back in idle. A border pixel returns to idle after calculate.
// Reset (synchronous, active low) clears position, window, running maximum, output
// valid and sets both size registers to 1024; the line memory is not cleared.
module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [PIX_W-1:0]            i_pixel,
    input  logic                        i_frame_start,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [GRAD_W-1:0]    o_grad_x,
    output logic signed [GRAD_W-1:0]    o_grad_y,
    output logic [MAG_W-1:0]            o_grad_magnitude,
    output logic [ROW_W-1:0]            o_centre_row,
    output logic [COL_OUT_W-1:0]        o_centre_col,
    output logic [MAG_W-1:0]            o_frame_max,
    output logic                        o_frame_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = CW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]             r_state;
    logic [CFG_W_W-1:0]     r_img_w;
    logic [CFG_H_W-1:0]     r_img_h;
    logic [CW-1:0]          r_col;
    logic [ROW_W-1:0]       r_row;
    logic [MAG_W-1:0]       r_max;
    logic [PIX_W-1:0]       r_win [6];
    logic                   r_interior;
    logic                   r_last;
    logic                   r_out_valid;

    logic [CW-1:0]          r_cur_col;
    logic [ROW_W-1:0]       r_cur_row;
    logic [PIX_W-1:0]       r_pix;
    logic [2*PIX_W-1:0]     r_line_rd;
    logic [2*PIX_W-1:0]     r_line_mem [MAX_WIDTH];
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    t_sqrt_state            r_sqrt;

    logic signed [GRAD_W-1:0] r_o_gx;
    logic signed [GRAD_W-1:0] r_o_gy;
    logic [MAG_W-1:0]       r_o_mag;
    logic [ROW_W-1:0]       r_o_row;
    logic [COL_OUT_W-1:0]   r_o_col;
    logic [MAG_W-1:0]       r_o_max;
    logic                   r_o_last;

    logic [EW-1:0]          w_eff;
    logic [EW-1:0]          w_m1;
    logic [ROW_W-1:0]       h_eff;
    logic [ROW_W-1:0]       h_m1;
    logic                   in_acc;
    logic                   out_acc;
    logic                   out_load;
    logic                   cfg_wr;
    logic [CW-1:0]          cur_col;
    logic [ROW_W-1:0]       cur_row;
    logic                   wrap_col;
    logic                   wrap_row;
    logic [CW-1:0]          n_col;
    logic [ROW_W-1:0]       n_row;
    logic [PIX_W-1:0]       c2t;
    logic [PIX_W-1:0]       c2m;
    logic [9:0]             sum_r;
    logic [9:0]             sum_l;
    logic [9:0]             sum_b;
    logic [9:0]             sum_t;
    logic signed [11:0]     gx_full;
    logic signed [11:0]     gy_full;
    logic signed [2*GRAD_W-1:0] sq_x;
    logic signed [2*GRAD_W-1:0] sq_y;
    logic [2*GRAD_W-1:0]    sq_sum;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       max_new;
    logic [CW-1:0]          col_m1;
    logic [ROW_W-1:0]       row_m1;

    // effective frame size
    always_comb begin
        if (r_img_w < CFG_W_W'(MIN_DIM)) begin
            w_eff = EW'(MIN_DIM);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_img_w);
        end
        h_eff = (r_img_h < CFG_H_W'(MIN_DIM)) ? CFG_H_W'(MIN_DIM) : r_img_h;
        w_m1  = w_eff - 1'b1;
        h_m1  = h_eff - 1'b1;
    end

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_acc    = r_out_valid && !i_out_stall;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cfg_wr     = psel && penable && pwrite;

    // position of the incoming pixel and the next one
    always_comb begin
        if (i_frame_start) begin
            cur_col = '0;
            cur_row = '0;
        end else begin
            cur_col = ({1'b0, r_col} >= w_eff) ? w_m1[CW-1:0] : r_col;
            cur_row = r_row;
        end
        wrap_col = ({1'b0, cur_col} >= w_m1);
        wrap_row = (cur_row >= h_m1);
        if (wrap_col) begin
            n_col = '0;
            n_row = wrap_row ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    // gradients
    always_comb begin
        c2t     = r_line_rd[2*PIX_W-1:PIX_W];
        c2m     = r_line_rd[PIX_W-1:0];
        sum_r   = 10'(c2t) + {1'b0, c2m, 1'b0} + 10'(r_pix);
        sum_l   = 10'(r_win[0]) + {1'b0, r_win[1], 1'b0} + 10'(r_win[2]);
        sum_b   = 10'(r_win[2]) + {1'b0, r_win[5], 1'b0} + 10'(r_pix);
        sum_t   = 10'(r_win[0]) + {1'b0, r_win[3], 1'b0} + 10'(c2t);
        gx_full = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l});
        gy_full = $signed({2'b00, sum_b}) - $signed({2'b00, sum_t});
        sq_x    = r_gx * r_gx;
        sq_y    = r_gy * r_gy;
        sq_sum  = $unsigned(sq_x) + $unsigned(sq_y);
        mag     = r_sqrt.res[MAG_W-1:0];
        max_new = (mag > r_max) ? mag : r_max;
        col_m1  = r_cur_col - 1'b1;
        row_m1  = r_cur_row - 1'b1;
    end

    // line memory: {two rows up, one row up} per column
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_line_mem[r_cur_col] <= {c2m, r_pix};
        end
        if (in_acc) begin
            r_line_rd <= r_line_mem[cur_col];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_img_w     <= WIDTH_RST;
            r_img_h     <= HEIGHT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_max       <= '0;
            r_interior  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_WIDTH: r_img_w <= pwdata[CFG_W_W-1:0];
                    REG_HEIGHT: r_img_h <= pwdata[CFG_H_W-1:0];
                    default: ;
                endcase
            end
            if (out_acc && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col      <= n_col;
                        r_row      <= n_row;
                        r_interior <= (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
                        r_last     <= wrap_col && wrap_row;
                        if (i_frame_start) begin
                            r_max <= '0;
                        end
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= c2t;
                    r_win[4] <= c2m;
                    r_win[5] <= r_pix;
                    if (r_interior) begin
                        r_state <= S_MUL;
                    end else begin
                        if (r_last) begin
                            r_max <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sqrt.bitv[0]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_max       <= r_last ? '0 : max_new;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur_col <= cur_col;
            r_cur_row <= cur_row;
            r_pix     <= i_pixel;
        end
        if (r_state == S_CALC) begin
            r_gx <= gx_full[GRAD_W-1:0];
            r_gy <= gy_full[GRAD_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_sqrt.rem  <= sq_sum[SQ_W-1:0];
            r_sqrt.res  <= '0;
            r_sqrt.bitv <= ROOT_BIT0;
        end else if (r_state == S_SQRT) begin
            r_sqrt <= sqrt_step(r_sqrt);
        end
        if (out_load) begin
            r_o_gx   <= r_gx;
            r_o_gy   <= r_gy;
            r_o_mag  <= mag;
            r_o_row  <= row_m1;
            r_o_col  <= COL_OUT_W'(col_m1);
            r_o_max  <= max_new;
            r_o_last <= r_last;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH: prdata = 32'(r_img_w);
            REG_HEIGHT: prdata = 32'(r_img_h);
            default: prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_grad_x         = r_o_gx;
    assign o_grad_y         = r_o_gy;
    assign o_grad_magnitude = r_o_mag;
    assign o_centre_row     = r_o_row;
    assign o_centre_col     = r_o_col;
    assign o_frame_max      = r_o_max;
    assign o_frame_last     = r_o_last;

`ifndef SYNTHESIS
    a_root_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_sqrt.bitv))
        else $error("root step bit not one-hot");

    a_max_covers_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_max >= o_grad_magnitude))
        else $error("frame maximum below magnitude");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside final state");
`endif

endmodule

// ===== tb/sv/sobel_gradient_magnitude_tb.sv =====
// Self-checking testbench for sobel_gradient_magnitude: random pixel streams, frame sizes
// and handshake stalls, checked against an in-bench Sobel window predictor.
// Depends on sgm_pkg and the sobel_gradient_magnitude RTL.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_tb;
    import sgm_pkg::*;

    localparam logic [2:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
    localparam logic [2:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PIXELS = 700;
    localparam int TALL_HEIGHT   = 4095;
    localparam int TALL_ROWS     = 40;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [MAG_W-1:0]         mag;
        logic [ROW_W-1:0]         row;
        logic [COL_OUT_W-1:0]     col;
        logic [MAG_W-1:0]         peak;
        logic                     last;
    } t_gradient;

    typedef enum {PAT_COL_BAR, PAT_ROW_BAR, PAT_NOISE} t_pattern;

    class t_gradient_scoreboard;
        logic [PIX_W-1:0] line_mem [2*MAX_WIDTH_DEF];
        int win [6];
        int col_pos, row_pos, peak;
        logic [CFG_W_W-1:0] cfg_width;
        logic [CFG_H_W-1:0] cfg_height;
        t_gradient expected_gradients [$];
        int errors, pixels_seen, results_checked, frames_closed, top_magnitude;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            cfg_width  = WIDTH_RST;
            cfg_height = HEIGHT_RST;
        endfunction

        static function int clamp_width(int v);
            if (v < MIN_DIM) return MIN_DIM;
            if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return v;
        endfunction

        function void set_register(logic [2:0] addr, logic [31:0] value);
            if (addr == WIDTH_ADDR) cfg_width = value[CFG_W_W-1:0];
            else if (addr == HEIGHT_ADDR) cfg_height = value[CFG_H_W-1:0];
        endfunction

        // Advances the window by one pixel transaction; queues the gradient it yields.
        function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
            int w, h, col, row, top, mid, cur, gx, gy, sq, root, trial;
            t_gradient want;
            pixels_seen++;
            w = clamp_width(cfg_width);
            h = (cfg_height < MIN_DIM) ? MIN_DIM : cfg_height;
            if (fs) begin
                col_pos = 0;
                row_pos = 0;
                peak = 0;
            end
            if (col_pos >= w) col_pos = w - 1;
            col = col_pos;
            row = row_pos;
            top = line_mem[col];
            mid = line_mem[MAX_WIDTH_DEF + col];
            cur = pix;
            if (row >= 2 && col >= 2) begin
                gx = (top + 2 * mid + cur) - (win[0] + 2 * win[1] + win[2]);
                gy = (win[2] + 2 * win[5] + cur) - (win[0] + 2 * win[3] + top);
                sq = gx * gx + gy * gy;
                root = 0;
                for (int b = 10; b >= 0; b--) begin
                    trial = root | (1 << b);
                    if (trial * trial <= sq) root = trial;
                end
                if (root > peak) peak = root;
                if (root > top_magnitude) top_magnitude = root;
                want.gx   = gx[GRAD_W-1:0];
                want.gy   = gy[GRAD_W-1:0];
                want.mag  = root[MAG_W-1:0];
                want.row  = ROW_W'(row - 1);
                want.col  = COL_OUT_W'(col - 1);
                want.peak = MAG_W'(peak);
                want.last = (row + 1 >= h) && (col + 1 >= w);
                if (want.last) frames_closed++;
                expected_gradients.push_back(want);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = cur;
            line_mem[col] = PIX_W'(mid);
            line_mem[MAX_WIDTH_DEF + col] = pix;
            if (col + 1 >= w) begin
                col_pos = 0;
                if (row + 1 >= h) begin
                    row_pos = 0;
                    peak = 0;
                end else begin
                    row_pos = row + 1;
                end
            end else begin
                col_pos = col + 1;
            end
        endfunction

        function void check_result(t_gradient got);
            t_gradient want;
            results_checked++;
            if (expected_gradients.size() == 0) begin
                if (errors < 200)
                    $display("%0t: unexpected result gx=%0d gy=%0d mag=%0d row=%0d col=%0d",
                             $time, got.gx, got.gy, got.mag, got.row, got.col);
                errors++;
                return;
            end
            want = expected_gradients.pop_front();
            if (got !== want) begin
                if (errors < 200) begin
                    $display(
                        "%0t: expected gx=%0d gy=%0d mag=%0d row=%0d col=%0d max=%0d last=%0d",
                        $time, want.gx, want.gy, want.mag, want.row, want.col, want.peak,
                        want.last);
                    $display(
                        "%0t: actual   gx=%0d gy=%0d mag=%0d row=%0d col=%0d max=%0d last=%0d",
                        $time, got.gx, got.gy, got.mag, got.row, got.col, got.peak,
                        got.last);
                end
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [PIX_W-1:0]         i_pixel = '0;
    logic                     i_frame_start = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [GRAD_W-1:0] o_grad_x;
    logic signed [GRAD_W-1:0] o_grad_y;
    logic [MAG_W-1:0]         o_grad_magnitude;
    logic [ROW_W-1:0]         o_centre_row;
    logic [COL_OUT_W-1:0]     o_centre_col;
    logic [MAG_W-1:0]         o_frame_max;
    logic                     o_frame_last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    t_gradient_scoreboard sb;
    t_gradient observed;
    bit quiet_mode = 1'b0;
    int sent_pixels = 0;
    int size_settings = 0;
    int stall_left = 0;
    int unsigned stall_roll;

    sobel_gradient_magnitude u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .i_frame_start    (i_frame_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_grad_x         (o_grad_x),
        .o_grad_y         (o_grad_y),
        .o_grad_magnitude (o_grad_magnitude),
        .o_centre_row     (o_centre_row),
        .o_centre_col     (o_centre_col),
        .o_frame_max      (o_frame_max),
        .o_frame_last     (o_frame_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("sobel_gradient_magnitude regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) sb.note_pixel(i_pixel, i_frame_start);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                observed = {o_grad_x, o_grad_y, o_grad_magnitude, o_centre_row, o_centre_col,
                            o_frame_max, o_frame_last};
                sb.check_result(observed);
            end
        end
    end

    // output back-pressure: mostly short stalls, a few long ones
    always @(posedge i_clk) begin
        if (quiet_mode) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            i_out_stall <= (stall_roll < 40);
            if (stall_roll < 36) stall_left <= $urandom_range(0, 3);
            else if (stall_roll < 40) stall_left <= $urandom_range(10, 40);
            else stall_left <= $urandom_range(0, 25);
        end
    end

    function automatic int idle_gap();
        int unsigned roll;
        if (quiet_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 16);
        return $urandom_range(17, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pattern_pixel(t_pattern pat, int r, int c);
        case (pat)
            PAT_COL_BAR: return (c == 2) ? 8'hFF : 8'h00;
            PAT_ROW_BAR: return (r == 2) ? 8'hFF : 8'h00;
            default: begin
                if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic apb_cycle(input logic write, input logic [2:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_register(input logic [2:0] addr);
        logic [31:0] got, want;
        apb_cycle(1'b0, addr, 32'd0, got);
        want = (addr == WIDTH_ADDR) ? 32'(sb.cfg_width) : 32'(sb.cfg_height);
        if (got !== want) begin
            $display("%0t: register at %0d expected %0d, actual %0d", $time, addr, want, got);
            sb.errors++;
        end
    endtask

    task automatic set_size(input logic [31:0] width_word, input logic [31:0] height_word);
        logic [31:0] ignored;
        apb_cycle(1'b1, WIDTH_ADDR, width_word, ignored);
        sb.set_register(WIDTH_ADDR, width_word);
        apb_cycle(1'b1, HEIGHT_ADDR, height_word, ignored);
        sb.set_register(HEIGHT_ADDR, height_word);
        verify_register(WIDTH_ADDR);
        verify_register(HEIGHT_ADDR);
        size_settings++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_pixels++;
    endtask

    task automatic send_frames(input t_pattern pat, input int w, input int h, input int count,
                               input bit mark_start, input bit noisy);
        int r, c;
        logic fs;
        for (int i = 0; i < count; i++) begin
            r = (i / w) % h;
            c = i % w;
            fs = (i == 0) ? mark_start : (noisy && $urandom_range(0, 149) == 0);
            send_pixel(pattern_pixel(pat, r, c), fs);
        end
    endtask

    // block is idle once every gradient is back and a border pixel has had time to finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_gradients.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int random_goal, eff_w, eff_h, span, n_pix;
        logic [31:0] w_word, h_word;
        bit mark;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        verify_register(WIDTH_ADDR);
        verify_register(HEIGHT_ADDR);

        // bright column: gx at both extremes
        set_size(32'd5, 32'd3);
        send_frames(PAT_COL_BAR, 5, 3, 15, 1'b1, 1'b0);
        drain();
        // bright row: gy at both extremes, frame entered through the end-of-frame wrap
        set_size(32'd3, 32'd5);
        send_frames(PAT_ROW_BAR, 3, 5, 15, 1'b0, 1'b0);
        drain();

        // saturating register values, then the top rows of the tallest frame
        quiet_mode = 1'b1;
        set_size(32'd2047, 32'd0);
        set_size(32'd1, 32'(TALL_HEIGHT));
        send_frames(PAT_NOISE, MIN_DIM, TALL_HEIGHT, MIN_DIM * TALL_ROWS, 1'b0, 1'b0);
        drain();
        quiet_mode = 1'b0;

        random_goal = sent_pixels + RANDOM_PIXELS;
        while (sent_pixels < random_goal) begin
            case ($urandom_range(0, 9))
                0: w_word = $urandom_range(0, 2);
                1: w_word = $urandom_range(13, 40);
                default: w_word = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0: h_word = $urandom_range(0, 2);
                1: h_word = $urandom_range(9, 20);
                default: h_word = $urandom_range(3, 8);
            endcase
            if ($urandom_range(0, 7) == 0) w_word |= $urandom & 32'hFFFF_F800;
            if ($urandom_range(0, 7) == 0) h_word |= $urandom & 32'hFFFF_F000;
            eff_w = t_gradient_scoreboard::clamp_width(w_word[CFG_W_W-1:0]);
            eff_h = (h_word[CFG_H_W-1:0] < MIN_DIM) ? MIN_DIM : h_word[CFG_H_W-1:0];
            // a wider row mid-frame would read line memory never filled: restart the frame
            mark = ($urandom_range(0, 3) == 0) ||
                   ((sb.col_pos != 0 || sb.row_pos != 0) &&
                    eff_w > t_gradient_scoreboard::clamp_width(sb.cfg_width));
            quiet_mode = ($urandom_range(0, 4) == 0);
            set_size(w_word, h_word);
            span = eff_w * eff_h;
            if ($urandom_range(0, 3) == 0) n_pix = $urandom_range(1, span - 1);
            else n_pix = span * $urandom_range(1, 2);
            if (n_pix > 300) n_pix = 300;
            send_frames(PAT_NOISE, eff_w, eff_h, n_pix, mark, 1'b1);
            drain();
        end

        $display("Pixel transactions: %0d, gradient results checked: %0d, size settings: %0d.",
                 sb.pixels_seen, sb.results_checked, size_settings);
        $display("Frames closed on their last interior pixel: %0d, largest magnitude: %0d.",
                 sb.frames_closed, sb.top_magnitude);
        if (sb.errors == 0) begin
            $display("sobel_gradient_magnitude regression: pass");
        end else begin
            $display("sobel_gradient_magnitude regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sgm_pkg.sv
hw/rtl/sobel_gradient_magnitude.sv
tb/sv/sobel_gradient_magnitude_tb.sv
